// ----- hw/rtl/mhpq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

    localparam int MHPQ_CAPACITY = 64;
    localparam int DATA_W        = 32;
    localparam int ENTRY_COUNT_W = 7;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef logic signed [DATA_W-1:0]  t_data;
    typedef logic [ENTRY_COUNT_W-1:0]  t_entry_count;

    typedef struct packed {
        t_op   op;
        t_data value;
    } t_in_item;

    typedef struct packed {
        t_data        min_value;
        t_entry_count entry_count;
        logic         is_empty;
        t_status      status;
    } t_out_item;

endpackage

`default_nettype wire

// ----- hw/rtl/mhpq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mhpq_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mhpq_seq #(
    parameter int CAPACITY = mhpq_pkg::MHPQ_CAPACITY,
    parameter int IW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire mhpq_pkg::t_in_item   i_in,
    output logic                      o_stall,
    output logic                      o_res_valid,
    output mhpq_pkg::t_out_item       o_res,
    input  wire logic                 i_res_stall,
    output logic                      o_wr_en,
    output logic [IW-1:0]             o_wr_addr,
    output logic [mhpq_pkg::DATA_W-1:0] o_wr_data,
    output logic [IW-1:0]             o_rd_addr,
    input  wire logic [mhpq_pkg::DATA_W-1:0] i_rd_data
);

    import mhpq_pkg::*;

    localparam int LW = IW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMPR,
        S_DN_CMPI,
        S_DONE
    } t_state;

    t_state        r_state,  n_state;
    logic [CW-1:0] r_count,  n_count;
    logic [IW-1:0] r_idx,    n_idx;
    logic [IW-1:0] r_par,    n_par;
    logic [IW-1:0] r_pick,   n_pick;
    t_data         r_item,   n_item;
    t_data         r_child,  n_child;
    t_data         r_root;
    t_status       r_status, n_status;

    t_data         w_rd;
    t_data         w_cmp_a;
    t_data         w_cmp_b;
    logic          w_lt;
    logic [LW-1:0] w_left;
    logic [CW-1:0] w_right;

    assign w_rd    = t_data'(i_rd_data);
    assign w_left  = {r_idx, 1'b1};
    assign w_right = CW'(r_pick) + CW'(1);

    // shared signed comparator
    always_comb begin
        unique case (r_state)
            S_UP_CMP:  begin w_cmp_a = r_item;  w_cmp_b = w_rd;    end
            S_DN_CMPR: begin w_cmp_a = w_rd;    w_cmp_b = r_child; end
            default:   begin w_cmp_a = r_child; w_cmp_b = r_item;  end
        endcase
    end

    assign w_lt = (w_cmp_a < w_cmp_b);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_par     = r_par;
        n_pick    = r_pick;
        n_item    = r_item;
        n_child   = r_child;
        n_status  = r_status;
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx;
        o_wr_data = r_item;
        o_rd_addr = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_status = ST_DONE;
                    if (i_in.op == OP_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_idx   = IW'(r_count);
                            n_item  = i_in.value;
                            n_count = r_count + CW'(1);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_idx   = '0;
                            if (r_count == CW'(1)) begin
                                n_state = S_DONE;
                            end else begin
                                o_rd_addr = IW'(r_count - CW'(1));
                                n_state   = S_DN_LOAD;
                            end
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_idx == '0) begin
                    o_wr_en = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_par     = (r_idx - IW'(1)) >> 1;
                    o_rd_addr = (r_idx - IW'(1)) >> 1;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_wr_en = 1'b1;
                if (w_lt) begin
                    o_wr_data = w_rd;
                    n_idx     = r_par;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DN_LOAD: begin
                n_item  = w_rd;
                n_state = S_DN_RDL;
            end
            S_DN_RDL: begin
                if (w_left >= LW'(r_count)) begin
                    o_wr_en = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_rd_addr = w_left[IW-1:0];
                    n_pick    = w_left[IW-1:0];
                    n_state   = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                n_child = w_rd;
                if (w_right < r_count) begin
                    o_rd_addr = r_pick + IW'(1);
                    n_state   = S_DN_CMPR;
                end else begin
                    n_state = S_DN_CMPI;
                end
            end
            S_DN_CMPR: begin
                if (w_lt) begin
                    n_child = w_rd;
                    n_pick  = r_pick + IW'(1);
                end
                n_state = S_DN_CMPI;
            end
            S_DN_CMPI: begin
                o_wr_en = 1'b1;
                if (w_lt) begin
                    o_wr_data = r_child;
                    n_idx     = r_pick;
                    n_state   = S_DN_RDL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_res_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_par    <= n_par;
        r_pick   <= n_pick;
        r_item   <= n_item;
        r_child  <= n_child;
        r_status <= n_status;
        if (o_wr_en && (o_wr_addr == '0)) begin
            r_root <= t_data'(o_wr_data);
        end
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.min_value   = (r_count != '0) ? r_root : '0;
    assign o_res.entry_count = t_entry_count'(r_count);
    assign o_res.is_empty    = (r_count == '0);
    assign o_res.status      = r_status;

endmodule

`default_nettype wire

// ----- hw/rtl/min_heap_priority_queue_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  payload     handshake
// request   in         t_in_item   i_valid / o_stall
// result    out        t_out_item  o_valid / i_stall
//
// one request at a time; o_stall is high from the accepting edge until the sequencer returns to idle
// insert: the new value moves up from the next free slot while it is less than its parent
// remove: the last entry moves down from the root while the smaller child is less than it
// full insert, empty remove and a remove that empties the heap go straight to the result
// reset clears the count; heap contents are not cleared
// a result waits in the output register while i_stall is high; a later result then holds in S_DONE, stalling requests

module min_heap_priority_queue_core #(
    parameter int CAPACITY = mhpq_pkg::MHPQ_CAPACITY
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire mhpq_pkg::t_in_item  i_in,
    output logic                     o_stall,
    output logic                     o_valid,
    output mhpq_pkg::t_out_item      o_out,
    input  wire logic                i_stall
);

    import mhpq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic              w_wr_en;
    logic [IW-1:0]     w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;
    logic [IW-1:0]     w_rd_addr;
    logic [DATA_W-1:0] w_rd_data;
    logic              w_res_valid;
    t_out_item         w_res;
    logic              w_res_stall;

    logic              r_out_valid;
    t_out_item         r_out;

    mhpq_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IW),
        .DATA_W (DATA_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    mhpq_seq #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in        (i_in),
        .o_stall     (o_stall),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_stall (w_res_stall),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    assign w_res_stall = r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!w_res_stall) begin
            r_out_valid <= w_res_valid;
        end
        if (!w_res_stall && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/mhpq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mhpq_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire mhpq_pkg::t_in_item  i_in,
    input wire logic                o_stall,
    input wire logic                o_valid,
    input wire mhpq_pkg::t_out_item o_out,
    input wire logic                i_stall
);

    import mhpq_pkg::*;

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.is_empty |-> (o_out.entry_count == '0) && (o_out.min_value == '0))
        else $error("empty result with nonzero count or minimum");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out.status == ST_FULL) |-> !o_out.is_empty)
        else $error("dropped insert reported on empty heap");

    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out.status == ST_EMPTY) |-> o_out.is_empty)
        else $error("ignored remove reported on nonempty heap");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block busy right after reset");

endmodule

bind min_heap_priority_queue_core mhpq_checker u_mhpq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .i_in    (i_in),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_out   (o_out),
    .i_stall (i_stall)
);

`default_nettype wire

// ----- dv/min_heap_priority_queue_core_tb.sv -----
`timescale 1ns / 1ps

module min_heap_priority_queue_core_tb;
    import mhpq_pkg::*;

    localparam int QUEUE_DEPTH = MHPQ_CAPACITY;
    localparam int MAX_IDLE    = 17;
    localparam int DRAIN_WAIT  = 48;
    localparam int HOLD_OFF    = 300;
    localparam int ITEM_TARGET = 950;

    class heap_shadow;
        t_data     slots[QUEUE_DEPTH];
        int        fill;
        t_out_item pending_results[$];
        int        errors;
        int        inserts;
        int        removes;
        int        full_drops;
        int        empty_removes;
        int        peak_fill;
        int        results_seen;

        function new();
            fill = 0;
            errors = 0;
            inserts = 0;
            removes = 0;
            full_drops = 0;
            empty_removes = 0;
            peak_fill = 0;
            results_seen = 0;
        endfunction

        function void take_request(t_in_item req);
            t_out_item outcome;
            t_status   st;
            t_data     moving;
            int        idx;
            int        parent;
            int        left;
            int        right;
            int        pick;
            st = ST_DONE;
            if (req.op == OP_INSERT) begin
                if (fill >= QUEUE_DEPTH) begin
                    st = ST_FULL;
                    full_drops++;
                end else begin
                    inserts++;
                    idx = fill;
                    fill++;
                    moving = req.value;
                    while (idx > 0) begin
                        parent = (idx - 1) / 2;
                        if (!(moving < slots[parent])) break;
                        slots[idx] = slots[parent];
                        idx = parent;
                    end
                    slots[idx] = moving;
                end
            end else if (fill == 0) begin
                st = ST_EMPTY;
                empty_removes++;
            end else begin
                removes++;
                fill--;
                if (fill > 0) begin
                    moving = slots[fill];
                    idx = 0;
                    while (1) begin
                        left = 2 * idx + 1;
                        right = left + 1;
                        if (left >= fill) break;
                        pick = left;
                        if (right < fill && slots[right] < slots[left]) pick = right;
                        if (!(slots[pick] < moving)) break;
                        slots[idx] = slots[pick];
                        idx = pick;
                    end
                    slots[idx] = moving;
                end
            end
            if (fill > peak_fill) peak_fill = fill;
            outcome.min_value   = (fill > 0) ? slots[0] : t_data'(0);
            outcome.entry_count = t_entry_count'(fill);
            outcome.is_empty    = (fill == 0);
            outcome.status      = st;
            pending_results.push_back(outcome);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: min_value %0d entry_count %0d",
                       got.min_value, got.entry_count);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.min_value !== want.min_value) begin
                $error("min_value: expected %0d, got %0d", want.min_value, got.min_value);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d",
                       want.entry_count, got.entry_count);
                errors++;
            end
            if (got.is_empty !== want.is_empty) begin
                $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    t_in_item  i_in;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_out;
    logic      i_stall;

    heap_shadow shadow;
    bit         tx_idle_on;
    bit         rx_idle_on;
    int         hold_off_req;
    int         sent;

    min_heap_priority_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_in    (i_in),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_out   (o_out),
        .i_stall (i_stall)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) shadow.take_request(i_in);
        if (i_rst_n && o_valid && !i_stall) shadow.check_result(o_out);
    end

    task automatic send_request(t_op op, t_data value);
        t_in_item req;
        int       gap;
        req.op = op;
        req.value = value;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= req;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    function automatic t_data pick_value();
        case ($urandom_range(0, 9))
            0: return t_data'(32'h7fff_ffff);
            1: return t_data'(32'h8000_0000);
            2, 3: return t_data'($urandom_range(0, 8) - 4);
            default: return t_data'($urandom);
        endcase
    endfunction

    // result side: random stall per transaction, plus one long hold-off on request
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            n = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold_off_req > 0) begin
                n = hold_off_req;
                hold_off_req = 0;
            end
            if (n > 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int  phase;
        int  span;
        int  insert_pct;
        bit  pressed;
        t_op op;
        shadow = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in = '0;
        i_stall = 1'b0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_off_req = 0;
        sent = 0;
        pressed = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, duplicates, removes down past empty
        send_request(OP_REMOVE, pick_value());
        send_request(OP_INSERT, t_data'(32'h7fff_ffff));
        send_request(OP_INSERT, t_data'(32'h8000_0000));
        send_request(OP_INSERT, t_data'(0));
        send_request(OP_INSERT, t_data'(-1));
        send_request(OP_INSERT, t_data'(5));
        send_request(OP_INSERT, t_data'(5));
        send_request(OP_INSERT, t_data'(5));
        send_request(OP_INSERT, t_data'(1));
        repeat (9) send_request(OP_REMOVE, pick_value());
        send_request(OP_INSERT, t_data'(32'h5555_5555));
        send_request(OP_INSERT, t_data'(32'haaaa_aaaa));
        send_request(OP_REMOVE, t_data'(32'hffff_ffff));
        send_request(OP_REMOVE, t_data'(0));

        // alternating fill, drain and mixed stretches
        phase = 0;
        while (sent < ITEM_TARGET) begin
            case (phase % 3)
                0: insert_pct = 85;
                1: insert_pct = 15;
                default: insert_pct = 50;
            endcase
            span = $urandom_range(60, 140);
            if (span > ITEM_TARGET - sent) span = ITEM_TARGET - sent;
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (!pressed && phase % 3 == 0) begin
                tx_idle_on = 1'b0;
                hold_off_req = HOLD_OFF;
                pressed = 1'b1;
            end
            repeat (span) begin
                op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
                send_request(op, pick_value());
            end
            phase++;
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (shadow.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run covered %0d requests: %0d inserts, %0d removes, %0d dropped when full,",
                 sent, shadow.inserts, shadow.removes, shadow.full_drops);
        $display("%0d removes on empty, peak fill %0d of %0d, %0d results checked",
                 shadow.empty_removes, shadow.peak_fill, QUEUE_DEPTH, shadow.results_seen);
        if (shadow.errors == 0 && shadow.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
